### src/hbp_pkg.sv
// Package for the Huffman bit packer: widths, table sizes, command codes
// and the controller state type. No dependencies.
package hbp_pkg;

  // Table and code sizes.
  localparam int MAX_CODE_LEN = 32;
  localparam int SYMBOL_COUNT = 256;
  localparam int CODE_W       = 32;
  localparam int LEN_W        = 6;
  localparam int SYM_W        = 8;
  localparam int CMD_W        = 2;
  localparam int BYTE_W       = 8;
  localparam int FILL_W       = 3;
  localparam int CNT_W        = LEN_W - FILL_W;
  localparam int ADDR_W       = $clog2(SYMBOL_COUNT);
  localparam int ENTRY_W      = LEN_W + CODE_W;
  localparam int BUF_W        = CODE_W + BYTE_W;
  localparam int LEN_CAP      = (MAX_CODE_LEN < CODE_W) ? MAX_CODE_LEN : CODE_W;

  // Stream payload widths.
  localparam int S_DATA_W = CMD_W + SYM_W + CODE_W + LEN_W;
  localparam int M_DATA_W = BYTE_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_LOAD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_ENCODE = 2'd1;
  localparam logic [CMD_W-1:0] CMD_FLUSH  = 2'd2;

  // Controller states.
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_EMIT
  } state_t;

endpackage

### src/huffman_bit_packer_core.sv
// Huffman bit packer: a code table in one RAM (code and length per symbol),
// a lookup stage that merges the code into the pending bits, and a byte emitter.
// Load writes the table directly. Encode reads the table through the registered
// RAM read, merges in the lookup state and then emits 0 to 4 bytes from the output
// shift register. Flush emits the pending byte as a single byte.
// Reset (rst, synchronous) clears the controller, the pending byte and the
// per-entry valid flops, so every length reads as zero; code data is not cleared.
module huffman_bit_packer_core (
  input  logic                          clk,
  input  logic                          rst,
  // Request fields from bit 0 up: command[1:0], symbol[9:2],
  // code_word[41:10], code_length[47:42].
  input  logic                          s_tvalid,
  output logic                          s_tready,
  input  logic [hbp_pkg::S_DATA_W-1:0]  s_tdata,
  // Result fields from bit 0 up: out_byte[7:0].
  output logic                          m_tvalid,
  input  logic                          m_tready,
  output logic [hbp_pkg::M_DATA_W-1:0]  m_tdata,
  output logic                          m_tlast
);

  import hbp_pkg::*;

  // Request fields.
  logic [CMD_W-1:0]  in_cmd;
  logic [SYM_W-1:0]  in_symbol;
  logic [CODE_W-1:0] in_code;
  logic [LEN_W-1:0]  in_len;
  logic [LEN_W-1:0]  in_len_sat;
  logic              in_range;
  logic              s_accept;

  assign in_cmd    = s_tdata[CMD_W-1:0];
  assign in_symbol = s_tdata[CMD_W+SYM_W-1:CMD_W];
  assign in_code   = s_tdata[CMD_W+SYM_W+CODE_W-1:CMD_W+SYM_W];
  assign in_len    = s_tdata[S_DATA_W-1:CMD_W+SYM_W+CODE_W];
  assign in_range  = {1'b0, in_symbol} < (SYM_W+1)'(SYMBOL_COUNT);
  assign in_len_sat = (in_len > LEN_W'(LEN_CAP)) ? LEN_W'(LEN_CAP) : in_len;
  assign s_accept  = s_tvalid && s_tready;

  // Registers.
  state_t              state, state_next;
  logic [BYTE_W-1:0]   pending, pending_next;
  logic [FILL_W-1:0]   fill, fill_next;
  logic [BUF_W-1:0]    buffer, buffer_next;
  logic [CNT_W-1:0]    count, count_next;
  logic                lk_hit, lk_hit_next;
  logic [SYMBOL_COUNT-1:0] valid;

  // Table RAM: length in the upper bits, code in the lower bits.
  logic               ram_we;
  logic [ENTRY_W-1:0] ram_rdata;

  assign ram_we = s_accept && (in_cmd == CMD_LOAD) && in_range;

  hbp_ram #(
    .WIDTH (ENTRY_W),
    .DEPTH (SYMBOL_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (in_symbol[ADDR_W-1:0]),
    .wdata ({in_len_sat, in_code}),
    .raddr (in_symbol[ADDR_W-1:0]),
    .rdata (ram_rdata)
  );

  // Merge of the looked-up code into the pending bits.
  logic [CODE_W-1:0] lk_code;
  logic [LEN_W-1:0]  lk_len;
  logic [LEN_W-1:0]  lk_shift;
  logic [CODE_W-1:0] lk_aligned;
  logic [BUF_W-1:0]  lk_placed;
  logic [BUF_W-1:0]  lk_buffer;
  logic [LEN_W-1:0]  lk_total;

  assign lk_code    = ram_rdata[CODE_W-1:0];
  assign lk_len     = lk_hit ? ram_rdata[ENTRY_W-1:CODE_W] : '0;
  assign lk_shift   = LEN_W'(CODE_W) - lk_len;
  assign lk_aligned = lk_code << lk_shift;
  assign lk_placed  = {lk_aligned, {BYTE_W{1'b0}}} >> fill;
  assign lk_buffer  = {pending, {CODE_W{1'b0}}} | lk_placed;
  assign lk_total   = {{(LEN_W-FILL_W){1'b0}}, fill} + lk_len;

  // Outputs come straight from registers.
  assign s_tready = (state == ST_IDLE);
  assign m_tvalid = (state == ST_EMIT);
  assign m_tdata  = buffer[BUF_W-1:BUF_W-BYTE_W];
  assign m_tlast  = (count == CNT_W'(1));

  // Next state and datapath.
  always_comb begin
    state_next   = state;
    pending_next = pending;
    fill_next    = fill;
    buffer_next  = buffer;
    count_next   = count;
    lk_hit_next  = lk_hit;
    unique case (state)
      ST_IDLE: begin
        if (s_accept) begin
          unique case (in_cmd)
            CMD_ENCODE: begin
              lk_hit_next = in_range && valid[in_symbol[ADDR_W-1:0]];
              state_next  = ST_LOOKUP;
            end
            CMD_FLUSH: begin
              buffer_next = {pending, {CODE_W{1'b0}}};
              count_next  = CNT_W'(1);
              fill_next   = '0;
              state_next  = ST_EMIT;
            end
            default: begin
              // Loads go to the RAM directly; unknown commands are dropped.
            end
          endcase
        end
      end
      ST_LOOKUP: begin
        if (lk_len == '0) begin
          state_next = ST_IDLE;
        end else if (lk_total[LEN_W-1:FILL_W] == '0) begin
          pending_next = lk_buffer[BUF_W-1:BUF_W-BYTE_W];
          fill_next    = lk_total[FILL_W-1:0];
          state_next   = ST_IDLE;
        end else begin
          buffer_next = lk_buffer;
          count_next  = lk_total[LEN_W-1:FILL_W];
          fill_next   = lk_total[FILL_W-1:0];
          state_next  = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (m_tready) begin
          buffer_next = buffer << BYTE_W;
          count_next  = count - CNT_W'(1);
          if (count == CNT_W'(1)) begin
            // The byte after the last full one holds the leftover bits.
            pending_next = buffer[BUF_W-BYTE_W-1:BUF_W-2*BYTE_W];
            state_next   = ST_IDLE;
          end
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // State and control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      pending <= '0;
      fill    <= '0;
      count   <= '0;
      lk_hit  <= 1'b0;
      valid   <= '0;
    end else begin
      state   <= state_next;
      pending <= pending_next;
      fill    <= fill_next;
      count   <= count_next;
      lk_hit  <= lk_hit_next;
      if (ram_we) begin
        valid[in_symbol[ADDR_W-1:0]] <= 1'b1;
      end
    end
  end

  // Output shift register needs no reset.
  always_ff @(posedge clk) begin
    buffer <= buffer_next;
  end

endmodule

### src/hbp_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
module hbp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### test/tb_huffman_bit_packer_core.sv
// Testbench for huffman_bit_packer_core: table loads, symbol encodes and flushes
// are checked byte by byte against a packing predictor kept in this file.
// Depends on hbp_pkg and huffman_bit_packer_core only.
`timescale 1ns / 1ps

module tb_huffman_bit_packer_core;
  import hbp_pkg::*;

  // Command 3 has no meaning in the block; it must be ignored.
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int RANDOM_REQUESTS = 300;
  localparam int DRAIN_CYCLES    = 20;

  typedef struct {
    logic [BYTE_W-1:0] data;
    logic              last;
  } packed_byte_t;

  // One row of the directed part; typed rows carry their bytes, first in the top bits.
  typedef struct {
    logic [CMD_W-1:0]  cmd;
    logic [SYM_W-1:0]  sym;
    logic [CODE_W-1:0] word;
    logic [LEN_W-1:0]  len;
    bit                typed;
    int                n_bytes;
    logic [31:0]       bytes;
  } stim_row_t;

  logic                clk;
  logic                rst;
  logic                s_tvalid;
  logic                s_tready;
  logic [S_DATA_W-1:0] s_tdata;
  logic                m_tvalid;
  logic                m_tready;
  logic [M_DATA_W-1:0] m_tdata;
  logic                m_tlast;

  // Predictor state: code table, pending byte and its fill count.
  logic [CODE_W-1:0] code_tbl [SYMBOL_COUNT];
  logic [LEN_W-1:0]  len_tbl  [SYMBOL_COUNT];
  logic [BYTE_W-1:0] pend_byte;
  int                pend_fill;

  packed_byte_t step_bytes[$];
  packed_byte_t bytes_due[$];
  stim_row_t    dir_rows[$];
  int           errors;
  int           no_gap_left;

  huffman_bit_packer_core uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Apply one request to the predictor; the bytes it causes land in step_bytes.
  function automatic void pack_bits(input logic [CMD_W-1:0] cmd, input logic [SYM_W-1:0] sym,
                                    input logic [CODE_W-1:0] word,
                                    input logic [LEN_W-1:0] len);
    logic [CODE_W-1:0] code;
    int                n;
    packed_byte_t      b;
    step_bytes.delete();
    case (cmd)
      CMD_LOAD: begin
        // Lengths beyond the widest code are clipped.
        code_tbl[sym] = word;
        len_tbl[sym]  = (len > LEN_CAP) ? LEN_W'(LEN_CAP) : len;
      end
      CMD_ENCODE: begin
        code = code_tbl[sym];
        n    = len_tbl[sym];
        // Shift the code in from its top valid bit, emitting every full byte.
        for (int i = n; i > 0; i--) begin
          if (code[i-1]) pend_byte[7 - pend_fill] = 1'b1;
          if (pend_fill == 7) begin
            b.data = pend_byte;
            b.last = 1'b0;
            step_bytes = {step_bytes, b};
            pend_byte = '0;
            pend_fill = 0;
          end else begin
            pend_fill++;
          end
        end
        if (step_bytes.size() > 0) step_bytes[$].last = 1'b1;
      end
      CMD_FLUSH: begin
        // A flush always yields a byte, empty or not.
        b.data = pend_byte;
        b.last = 1'b1;
        step_bytes = {step_bytes, b};
        pend_byte = '0;
        pend_fill = 0;
      end
      default: ;
    endcase
  endfunction

  // Sender idle length: mostly none or short, a few long, with bursts of none.
  function automatic int gap_len();
    int r;
    if (no_gap_left > 0) begin
      no_gap_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 4) no_gap_left = $urandom_range(10, 40);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 8);
    return $urandom_range(15, 40);
  endfunction

  // Present one request, wait for it to be taken and record the bytes it owes.
  task automatic send(input stim_row_t row);
    int           gap;
    packed_byte_t b;
    gap = gap_len();
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {row.len, row.word, row.sym, row.cmd};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    pack_bits(row.cmd, row.sym, row.word, row.len);
    if (row.typed) begin
      for (int k = 0; k < row.n_bytes; k++) begin
        b.data = row.bytes[31 - 8*k -: 8];
        b.last = (k == row.n_bytes - 1);
        bytes_due = {bytes_due, b};
      end
    end else begin
      bytes_due = {bytes_due, step_bytes};
    end
  endtask

  // Table indexes crowd into a small range so encodes mostly hit loaded entries.
  function automatic logic [SYM_W-1:0] pick_sym();
    if ($urandom_range(0, 99) < 80) return SYM_W'($urandom_range(0, 15));
    return SYM_W'($urandom_range(0, 255));
  endfunction

  function automatic logic [LEN_W-1:0] pick_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return '0;
    if (r < 75) return LEN_W'($urandom_range(1, 12));
    if (r < 92) return LEN_W'($urandom_range(13, 32));
    return LEN_W'($urandom_range(33, 63));
  endfunction

  // Result side stalls: ready bursts separated by mostly short, rarely long gaps.
  initial begin
    int n;
    int gap;
    forever begin
      n   = ($urandom_range(0, 9) == 0) ? $urandom_range(30, 80) : $urandom_range(1, 6);
      gap = ($urandom_range(0, 19) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
      m_tready <= 1'b0;
      repeat (gap) @(posedge clk);
      m_tready <= 1'b1;
      repeat (n) @(posedge clk);
    end
  end

  // Compare every taken byte with the oldest one owed.
  always @(posedge clk) begin
    packed_byte_t b;
    if (!rst && m_tvalid && m_tready) begin
      if (bytes_due.size() == 0) begin
        $error("unexpected byte %h (last %b)", m_tdata, m_tlast);
        errors++;
      end else begin
        b = bytes_due.pop_front();
        if (m_tdata !== b.data) begin
          $error("out_byte: expected %h, got %h", b.data, m_tdata);
          errors++;
        end
        if (m_tlast !== b.last) begin
          $error("last_of_run: expected %b, got %b", b.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // Run limit.
  initial begin
    #5ms;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    stim_row_t row;
    int        sent;
    int        r;
    errors      = 0;
    no_gap_left = 0;
    pend_byte   = '0;
    pend_fill   = 0;
    foreach (code_tbl[i]) code_tbl[i] = '0;
    foreach (len_tbl[i]) len_tbl[i] = '0;
    rst      <= 1'b1;
    s_tvalid <= 1'b0;
    s_tdata  <= '0;

    // Directed rows: cmd, symbol, code, length, typed, byte count, bytes.
    dir_rows = '{
      // Flush straight after reset gives an empty byte.
      '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b1, 1, 32'h0000_0000},
      // Nothing loaded yet, so encoding gives nothing.
      '{CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 0, 32'h0000_0000},
      '{CMD_LOAD,   8'h00, 32'hFFFF_FFFF, 6'd8,  1'b1, 0, 32'h0000_0000},
      '{CMD_ENCODE, 8'h00, 32'h0000_0000, 6'd0,  1'b1, 1, 32'hFF00_0000},
      // Full 32-bit code with only its end bits set.
      '{CMD_LOAD,   8'hFF, 32'h8000_0001, 6'd32, 1'b1, 0, 32'h0000_0000},
      '{CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b1, 4, 32'h8000_0001},
      // Oversize length is clipped to 32.
      '{CMD_LOAD,   8'h01, 32'hFFFF_FFFF, 6'd63, 1'b1, 0, 32'h0000_0000},
      '{CMD_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b1, 4, 32'hFFFF_FFFF},
      '{CMD_LOAD,   8'h02, 32'h0000_0001, 6'd1,  1'b1, 0, 32'h0000_0000},
      '{CMD_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b1, 0, 32'h0000_0000},
      '{CMD_FLUSH,  8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 1, 32'h8000_0000},
      // Unknown command with every bit set is dropped.
      '{CMD_UNUSED, 8'hFF, 32'hFFFF_FFFF, 6'd63, 1'b1, 0, 32'h0000_0000},
      // A zero-length entry emits nothing.
      '{CMD_LOAD,   8'h03, 32'hAAAA_AAAA, 6'd0,  1'b1, 0, 32'h0000_0000},
      '{CMD_ENCODE, 8'h03, 32'h0000_0000, 6'd0,  1'b1, 0, 32'h0000_0000},
      // Codes straddling byte boundaries.
      '{CMD_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b0, 0, 32'h0000_0000},
      '{CMD_ENCODE, 8'h01, 32'h0000_0000, 6'd0,  1'b0, 0, 32'h0000_0000},
      '{CMD_ENCODE, 8'hFF, 32'h0000_0000, 6'd0,  1'b0, 0, 32'h0000_0000},
      '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 0, 32'h0000_0000},
      '{CMD_LOAD,   8'h04, 32'h1555_5555, 6'd30, 1'b0, 0, 32'h0000_0000},
      '{CMD_ENCODE, 8'h04, 32'h0000_0000, 6'd0,  1'b0, 0, 32'h0000_0000},
      '{CMD_ENCODE, 8'h02, 32'h0000_0000, 6'd0,  1'b0, 0, 32'h0000_0000},
      '{CMD_FLUSH,  8'h00, 32'h0000_0000, 6'd0,  1'b0, 0, 32'h0000_0000},
      '{CMD_LOAD,   8'h80, 32'h0000_0000, 6'd32, 1'b1, 0, 32'h0000_0000},
      '{CMD_ENCODE, 8'h80, 32'h0000_0000, 6'd0,  1'b1, 4, 32'h0000_0000}
    };

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (dir_rows[i]) send(dir_rows[i]);

    // Random part: loads, encodes, flushes and unknown commands with random unused fields.
    sent = 0;
    row.typed   = 1'b0;
    row.n_bytes = 0;
    row.bytes   = '0;
    while (sent < RANDOM_REQUESTS) begin
      r        = $urandom_range(0, 99);
      row.sym  = pick_sym();
      row.word = $urandom;
      row.len  = pick_len();
      if (r < 25)      row.cmd = CMD_LOAD;
      else if (r < 82) row.cmd = CMD_ENCODE;
      else if (r < 94) row.cmd = CMD_FLUSH;
      else             row.cmd = CMD_UNUSED;
      send(row);
      if (row.cmd != CMD_UNUSED) sent++;
    end
    // The last request was taken at this edge; withdraw it at once.
    s_tvalid <= 1'b0;

    // Drain, then give the block time to show any stray byte.
    while (bytes_due.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0 && bytes_due.size() == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
